FILE: hw/rtl/rmsld_pkg.sv
// Shared constants, payload types and control types for the RMS level detector.
package rmsld_pkg;

  localparam int HISTORY_DEPTH = 600;
  localparam int MAX_BLOCK     = 8192;

  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 44;
  localparam int CNT_W    = $clog2(MAX_BLOCK + 1);
  localparam int FRAC_W   = 16;
  localparam int MS_W     = 47;
  localparam int RMS_W    = 24;
  localparam int TOT_W    = 34;
  localparam int RUN_W    = 8;

  localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HIST_W = $clog2(HISTORY_DEPTH + 1);
  localparam int PROD_W = RMS_W + HIST_W;
  localparam int CMP_W  = (PROD_W > TOT_W) ? PROD_W : TOT_W;

  localparam int DVD_W      = SUM_W + FRAC_W;
  localparam int DVS_W      = (CNT_W > HIST_W) ? CNT_W : HIST_W;
  localparam int DIV_ITER_W = $clog2(DVD_W + 1);

  localparam int RAD_W     = 2 * RMS_W;
  localparam int REM_W     = RMS_W + 2;
  localparam int SQ_ITER_W = $clog2(RMS_W + 1);

  // window average as a reciprocal multiply, exact for any ring total below 2**TOT_W
  localparam int AVG_SH     = TOT_W + $clog2(HISTORY_DEPTH);
  localparam int RCP_W      = TOT_W + 1;
  localparam int AVG_HALF_W = (TOT_W + 1) / 2;
  localparam int AVG_PP_W   = AVG_HALF_W + RCP_W;
  localparam int AVG_ACC_W  = 2 * AVG_HALF_W + RCP_W;
  localparam logic [RCP_W-1:0] AVG_RECIP =
    RCP_W'(((64'd1 << AVG_SH) + 64'(HISTORY_DEPTH) - 64'd1) / 64'(HISTORY_DEPTH));

  localparam logic [RMS_W-1:0] LEVEL_BASELINE = RMS_W'(20480);
  localparam logic [TOT_W-1:0] RING_RESET_TOTAL =
    TOT_W'(64'(HISTORY_DEPTH) * 64'(20480));
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } in_data_t;

  typedef struct packed {
    logic [RMS_W-1:0] rms_level;
    logic [RMS_W-1:0] window_average;
    logic             above_average;
    logic [RUN_W-1:0] run_length;
  } out_data_t;

  typedef struct packed {
    logic rd_en;
    logic upd_en;
  } ring_ctl_t;

  typedef struct packed {
    logic             above;
    logic [RUN_W-1:0] run_length;
  } ring_res_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_DRAIN,
    ST_DIV_MS,
    ST_WAIT_MS,
    ST_AVG_HI,
    ST_AVG_LO,
    ST_WAIT_SQ,
    ST_RING_RD,
    ST_RING_UPD
  } state_t;

endpackage

FILE: hw/rtl/block_rms_level_detector.sv
// Top level of the RMS level detector: sample accumulator, block-end sequencer, output register.
//
// Input channel in_valid/in_stall/in_data carries one signed 16-bit sample per
// request; block_end marks the last sample of a block. Samples are taken one
// per cycle while in_stall is low. A block_end request closes the block and
// in_stall then stays high while the sequencer folds in the last square and
// loads the divider, runs the bit-serial divide of the sum of squares by the
// count and the bit-serial root with its handoff, and does the ring read and
// write. The window average comes from a reciprocal multiply, high half then
// low half, that runs beside the root. The ring write also loads the result
// request into out_valid/out_data. Only a block_end sample produces a result.
// The result sits in an output register: a stalled receiver holds it there
// while the next block's samples keep flowing in; only the ring update of the
// following block waits for that register to drain.
// Reset (rst_n low, synchronous) clears the accumulator, the run counter and
// the ring pointer and loads the ring total with the baseline; ring entries
// read as the baseline until written, so no clearing pass is needed.
module block_rms_level_detector
  import rmsld_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_data_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_data_t out_data
);

  state_t state_r, state_nxt;

  logic [SQ_W-1:0]  sq_r;
  logic             add_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_data_t out_data_r;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                         in_accept;
  logic                         acc_clear;
  logic                         out_free;

  logic             div_start;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic             div_busy;
  logic [DVD_W-1:0] div_quotient;

  logic             sqrt_start;
  logic             sqrt_busy;
  logic [RMS_W-1:0] sqrt_root;

  ring_ctl_t        ring_ctl;
  logic [TOT_W-1:0] ring_total;
  ring_res_t        ring_res;

  logic                    avg_hi_en;
  logic                    avg_lo_en;
  logic [2*AVG_HALF_W-1:0] avg_x;
  logic [AVG_HALF_W-1:0]   avg_op;
  logic [AVG_PP_W-1:0]     avg_pp;
  logic [AVG_ACC_W-1:0]    avg_acc_r;

  assign in_stall  = (state_r != ST_RUN);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign sq_full   = in_data.sample * in_data.sample;

  // square in the accept cycle, accumulate in the next
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (acc_clear) begin
      sum_nxt   = '0;
      count_nxt = '0;
    end else begin
      if (add_r) begin
        sum_nxt = sum_r + SUM_W'(sq_r);
      end
      if (in_accept && count_r < CNT_W'(MAX_BLOCK)) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r   <= 1'b0;
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      add_r   <= in_accept && count_r < CNT_W'(MAX_BLOCK);
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    acc_clear       = 1'b0;
    div_start       = 1'b0;
    div_dividend    = {sum_r, FRAC_W'(0)};
    div_divisor     = (count_r == '0) ? DVS_W'(1) : DVS_W'(count_r);
    sqrt_start      = 1'b0;
    avg_hi_en       = 1'b0;
    avg_lo_en       = 1'b0;
    ring_ctl.rd_en  = 1'b0;
    ring_ctl.upd_en = 1'b0;
    case (state_r)
      ST_RUN: begin
        if (in_accept && in_data.block_end) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIV_MS;
      end
      ST_DIV_MS: begin
        div_start = 1'b1;
        acc_clear = 1'b1;
        state_nxt = ST_WAIT_MS;
      end
      ST_WAIT_MS: begin
        if (!div_busy) begin
          sqrt_start = 1'b1;
          state_nxt  = ST_AVG_HI;
        end
      end
      ST_AVG_HI: begin
        avg_hi_en = 1'b1;
        state_nxt = ST_AVG_LO;
      end
      ST_AVG_LO: begin
        avg_lo_en = 1'b1;
        state_nxt = ST_WAIT_SQ;
      end
      ST_WAIT_SQ: begin
        if (!sqrt_busy) begin
          state_nxt = ST_RING_RD;
        end
      end
      ST_RING_RD: begin
        ring_ctl.rd_en = 1'b1;
        state_nxt      = ST_RING_UPD;
      end
      ST_RING_UPD: begin
        // hold until the output register can take the new result
        if (out_free) begin
          ring_ctl.upd_en = 1'b1;
          state_nxt       = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  rmsld_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  rmsld_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (div_quotient[MS_W-1:0]),
    .busy     (sqrt_busy),
    .root     (sqrt_root)
  );

  rmsld_ring u_ring (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ring_ctl),
    .rms   (sqrt_root),
    .total (ring_total),
    .res   (ring_res)
  );

  assign avg_x  = (2*AVG_HALF_W)'(ring_total);
  assign avg_op = avg_hi_en ? avg_x[2*AVG_HALF_W-1 -: AVG_HALF_W] : avg_x[AVG_HALF_W-1:0];
  assign avg_pp = AVG_PP_W'(avg_op) * AVG_PP_W'(AVG_RECIP);

  // multiply the ring total by the reciprocal of the depth, high half first
  always_ff @(posedge clk) begin
    if (avg_hi_en) begin
      avg_acc_r <= AVG_ACC_W'(avg_pp);
    end else if (avg_lo_en) begin
      avg_acc_r <= (avg_acc_r << AVG_HALF_W) + AVG_ACC_W'(avg_pp);
    end
  end

  always_comb begin
    if (ring_ctl.upd_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_ctl.upd_en) begin
      out_data_r.rms_level      <= sqrt_root;
      out_data_r.window_average <= avg_acc_r[AVG_SH +: RMS_W];
      out_data_r.above_average  <= ring_res.above;
      out_data_r.run_length     <= ring_res.run_length;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BLOCK))
    else $error("sample count beyond block limit");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_sqrt_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    sqrt_start |-> !sqrt_busy)
    else $error("root unit restarted while busy");

  a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ring_ctl.upd_en))
    else $error("result request without ring update");
`endif

endmodule

FILE: hw/rtl/rmsld_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rmsld_div
  import rmsld_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  logic                  busy_r;
  logic [DIV_ITER_W-1:0] cnt_r;
  logic [DVS_W-1:0]      rem_r;
  logic [DVS_W-1:0]      dvs_r;
  logic [DVD_W-1:0]      quo_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           fit;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fit   = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == DIV_ITER_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  // shift the dividend out at the top, the quotient in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= DIV_ITER_W'(DVD_W);
    end else if (busy_r) begin
      rem_r <= fit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], fit};
      cnt_r <= cnt_r - DIV_ITER_W'(1);
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: hw/rtl/rmsld_sqrt.sv
// Bit-serial integer square root, one root bit per cycle.
module rmsld_sqrt
  import rmsld_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [MS_W-1:0]  radicand,
  output logic             busy,
  output logic [RMS_W-1:0] root
);

  logic                 busy_r;
  logic [SQ_ITER_W-1:0] cnt_r;
  logic [RAD_W-1:0]     rad_r;
  logic [REM_W-1:0]     rem_r;
  logic [RMS_W-1:0]     root_r;

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fit;

  assign rem2  = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_r, 2'b01});
  assign diff  = rem2 - trial;
  assign fit   = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == SQ_ITER_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  // bring down two radicand bits per step
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= RAD_W'(radicand);
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= SQ_ITER_W'(RMS_W);
    end else if (busy_r) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= fit ? diff[REM_W-1:0] : rem2[REM_W-1:0];
      root_r <= {root_r[RMS_W-2:0], fit};
      cnt_r  <= cnt_r - SQ_ITER_W'(1);
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: hw/rtl/rmsld_ring.sv
// Level history ring: memory of past block levels, running total and run counter.
module rmsld_ring
  import rmsld_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ring_ctl_t        ctl,
  input  logic [RMS_W-1:0] rms,
  output logic [TOT_W-1:0] total,
  output ring_res_t        res
);

  logic [RMS_W-1:0] mem [HISTORY_DEPTH];

  logic [RMS_W-1:0]  rd_q_r;
  logic [PROD_W-1:0] prod_r;
  logic [POS_W-1:0]  pos_r;
  logic              wrapped_r;
  logic [TOT_W-1:0]  total_r;
  logic [RUN_W-1:0]  run_r;

  logic [RMS_W-1:0] old_level;
  logic             above;
  logic [RUN_W-1:0] run_nxt;
  logic [TOT_W-1:0] total_nxt;

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      mem[pos_r] <= rms;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[pos_r];
      prod_r <= PROD_W'(rms) * PROD_W'(HISTORY_DEPTH);
    end
  end

  // entries ahead of the write pointer keep the baseline until the first wrap
  assign old_level = wrapped_r ? rd_q_r : LEVEL_BASELINE;
  assign above     = CMP_W'(prod_r) > CMP_W'(total_r);
  assign total_nxt = total_r - TOT_W'(old_level) + TOT_W'(rms);

  always_comb begin
    if (!above) begin
      run_nxt = '0;
    end else if (run_r == RUN_MAX) begin
      run_nxt = run_r;
    end else begin
      run_nxt = run_r + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      total_r   <= RING_RESET_TOTAL;
      run_r     <= '0;
    end else if (ctl.upd_en) begin
      total_r <= total_nxt;
      run_r   <= run_nxt;
      if (pos_r == POS_W'(HISTORY_DEPTH - 1)) begin
        pos_r     <= '0;
        wrapped_r <= 1'b1;
      end else begin
        pos_r <= pos_r + POS_W'(1);
      end
    end
  end

  assign total          = total_r;
  assign res.above      = above;
  assign res.run_length = run_nxt;

endmodule
